@@ rtl/dct_pkg.sv @@
package dct_pkg;

	typedef enum logic [2:0] {
		ST_NO = 3'd0,
		ST_RQ = 3'd1,
		ST_RS = 3'd2,
		ST_PO = 3'd3,
		ST_OP = 3'd4,
		ST_CR = 3'd5,
		ST_CG = 3'd6,
		ST_TW = 3'd7
	} state_t;

	typedef enum logic [2:0] {
		V_ACCEPT  = 3'd0,
		V_IGNORE  = 3'd1,
		V_INVALID = 3'd2,
		V_KILL    = 3'd3,
		V_REFUSED = 3'd4
	} verdict_t;

	// Transition table codes: the eight states plus IGNORE and INVALID
	localparam logic [3:0] NX_NO = 4'd0;
	localparam logic [3:0] NX_RQ = 4'd1;
	localparam logic [3:0] NX_RS = 4'd2;
	localparam logic [3:0] NX_PO = 4'd3;
	localparam logic [3:0] NX_OP = 4'd4;
	localparam logic [3:0] NX_CR = 4'd5;
	localparam logic [3:0] NX_CG = 4'd6;
	localparam logic [3:0] NX_TW = 4'd7;
	localparam logic [3:0] NX_IG = 4'd8;
	localparam logic [3:0] NX_IV = 4'd9;

	localparam logic [3:0] TY_REQUEST  = 4'd0;
	localparam logic [3:0] TY_RESPONSE = 4'd1;
	localparam logic [3:0] TY_ACK      = 4'd3;
	localparam logic [3:0] TY_RESET    = 4'd7;
	localparam logic [3:0] TY_COUNT    = 4'd10;

	localparam int NUM_TMO = 7;

	// Configuration register indexes
	localparam logic [2:0] CFG_PICKUP   = 3'd0;
	localparam logic [2:0] CFG_TMO_RQ   = 3'd1;
	localparam logic [2:0] CFG_TMO_RS   = 3'd2;
	localparam logic [2:0] CFG_TMO_PO   = 3'd3;
	localparam logic [2:0] CFG_TMO_OP   = 3'd4;
	localparam logic [2:0] CFG_TMO_CR   = 3'd5;
	localparam logic [2:0] CFG_TMO_CG   = 3'd6;
	localparam logic [2:0] CFG_TMO_TW   = 3'd7;

	localparam logic [31:0] TMO_RESET [NUM_TMO] = '{
		32'd24000, 32'd48000, 32'd48000, 32'd4320000, 32'd6400, 32'd6400, 32'd24000
	};

	// [role][type][state], role 0 client, 1 server
	localparam logic [3:0] NS_TBL [2][10][8] = '{
		'{
			'{NX_RQ, NX_RQ, NX_RS, NX_IG, NX_IG, NX_IG, NX_IG, NX_RQ},
			'{NX_IV, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_IV, NX_OP, NX_CR, NX_CG, NX_IV},
			'{NX_IV, NX_IV, NX_PO, NX_PO, NX_OP, NX_CR, NX_CG, NX_IV},
			'{NX_IV, NX_IV, NX_PO, NX_PO, NX_OP, NX_CR, NX_CG, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_CG, NX_CG, NX_CG, NX_IV, NX_IV},
			'{NX_IV, NX_TW, NX_TW, NX_TW, NX_TW, NX_TW, NX_TW, NX_IG},
			'{NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG},
			'{NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG}
		},
		'{
			'{NX_IV, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_RQ},
			'{NX_IV, NX_RS, NX_RS, NX_IG, NX_IG, NX_IG, NX_IG, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_OP, NX_OP, NX_IV, NX_CG, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_OP, NX_OP, NX_IV, NX_CG, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_OP, NX_OP, NX_IV, NX_CG, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_CR, NX_CR, NX_CR, NX_CR, NX_IV},
			'{NX_IV, NX_IV, NX_IV, NX_CG, NX_CG, NX_IV, NX_CG, NX_IV},
			'{NX_IV, NX_TW, NX_TW, NX_TW, NX_TW, NX_TW, NX_TW, NX_IG},
			'{NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG},
			'{NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG}
		}
	};

	typedef struct packed {
		logic        func;
		logic        direction;
		logic [3:0]  pkt_type;
		logic [47:0] seq_number;
		logic [47:0] ack_number;
		logic        reply_seen;
	} pkt_t;

	typedef struct packed {
		state_t      track;
		logic        orig_srv;
		logic [3:0]  prior_type;
		logic        prior_dir;
		logic [47:0] hs_seq;
		logic        assured;
	} trk_t;

	typedef struct packed {
		verdict_t    verdict;
		state_t      conn_state;
		logic        changed;
		logic        assured;
		logic [31:0] ticks;
	} res_t;

	localparam trk_t TRK_RESET = '{
		track:      ST_NO,
		orig_srv:   1'b0,
		prior_type: TY_REQUEST,
		prior_dir:  1'b0,
		hs_seq:     48'd0,
		assured:    1'b0
	};

	function automatic logic [3:0] ns_lookup(input logic role, input logic [3:0] ty,
			input logic [2:0] st);
		logic [3:0] r;
		r = NX_IV;
		if (ty < TY_COUNT) begin
			r = NS_TBL[role][ty][st];
		end
		return r;
	endfunction

endpackage

@@ rtl/dccp_connection_tracker_unit.sv @@
// A packet passes the input register, then the result register, before its result transfer.
// Throughput: one packet per cycle; the connection state updates as a packet moves
// from the input register into the result register, so the next packet sees it at once.
// A result held by out_ready low keeps stage 1 full and drops in_ready until it drains.
// Reset (arst_n low, asynchronous): tracker cleared to state none, client role,
// assured mark clear; pickup_midstream 1 and refresh timeouts at their defaults.
module dccp_connection_tracker_unit import dct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// packet input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic        direction,
	input  logic [3:0]  pkt_type,
	input  logic [47:0] seq_number,
	input  logic [47:0] ack_number,
	input  logic        reply_seen,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  verdict,
	output logic [2:0]  conn_state,
	output logic        state_changed,
	output logic        assured,
	output logic [31:0] refresh_ticks,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	// Input register stage
	logic        vld_s1;
	pkt_t        pkt_s1;
	// Result register
	logic        out_vld_q;
	res_t        res_q;
	// Connection state and configuration
	trk_t        trk_q;
	logic        pickup_q;
	logic [31:0] tmo_q [NUM_TMO];

	trk_t        trk_nxt;
	res_t        res_nxt;
	logic        adv;

	// The stage-1 packet moves into the result register whenever that register
	// is empty or is being drained in this cycle.
	assign adv      = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pkt_s1 <= '{
				func:       func,
				direction:  direction,
				pkt_type:   pkt_type,
				seq_number: seq_number,
				ack_number: ack_number,
				reply_seen: reply_seen
			};
		end
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	// Connection state commits only when a packet transfers out of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= TRK_RESET;
		end else if (adv) begin
			trk_q <= trk_nxt;
		end
	end

	// Configuration registers; the user must write them only while no packet is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pickup_q <= 1'b1;
			tmo_q    <= TMO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PICKUP: pickup_q  <= cfg_wdata[0];
				CFG_TMO_RQ: tmo_q[0]  <= cfg_wdata;
				CFG_TMO_RS: tmo_q[1]  <= cfg_wdata;
				CFG_TMO_PO: tmo_q[2]  <= cfg_wdata;
				CFG_TMO_OP: tmo_q[3]  <= cfg_wdata;
				CFG_TMO_CR: tmo_q[4]  <= cfg_wdata;
				CFG_TMO_CG: tmo_q[5]  <= cfg_wdata;
				CFG_TMO_TW: tmo_q[6]  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Single-pass transition: table lookup plus the special-case rules
	dct_step u_step (
		.pkt     (pkt_s1),
		.trk     (trk_q),
		.pickup  (pickup_q),
		.tmo     (tmo_q),
		.trk_nxt (trk_nxt),
		.res     (res_nxt)
	);

	assign out_valid     = out_vld_q;
	assign verdict       = res_q.verdict;
	assign conn_state    = res_q.conn_state;
	assign state_changed = res_q.changed;
	assign assured       = res_q.assured;
	assign refresh_ticks = res_q.ticks;

	// Only an accepted packet may carry a refresh timeout
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.verdict != V_ACCEPT |-> res_q.ticks == '0)
		else $error("refresh ticks on non-accept verdict");

	// A refused open never alters the tracked state
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nxt.verdict == V_REFUSED |=> trk_q == $past(trk_q))
		else $error("refused open changed tracker");

	// A kill leaves the tracker cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nxt.verdict == V_KILL |=> trk_q.track == ST_NO && !trk_q.assured)
		else $error("kill did not clear tracker");

	// An accepted packet always lands in a real state
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.verdict == V_ACCEPT |-> res_q.conn_state != ST_NO)
		else $error("accept into state none");

	// Reported state matches the stored state it produced
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_q.conn_state == trk_q.track)
		else $error("result state differs from tracker");

endmodule

@@ rtl/dct_step.sv @@
module dct_step import dct_pkg::*; (
	input  pkt_t        pkt,
	input  trk_t        trk,
	input  logic        pickup,
	input  logic [31:0] tmo [NUM_TMO],
	output trk_t        trk_nxt,
	output res_t        res
);

	trk_t       base;
	logic [3:0] s0;
	logic [3:0] ns;
	logic [3:0] fin;
	logic       role;
	logic [2:0] tidx;
	verdict_t   vd;
	logic [31:0] ticks;

	always_comb begin
		base    = trk;
		trk_nxt = trk;
		vd      = V_INVALID;
		ticks   = '0;
		role    = 1'b0;
		ns      = NX_IV;
		fin     = NX_IV;
		tidx    = '0;
		s0      = ns_lookup(1'b0, pkt.pkt_type, 3'(ST_NO));

		if (pkt.pkt_type >= TY_COUNT) begin
			vd = V_INVALID;
		end else if (pkt.func && (s0 == NX_IV || (s0 != NX_RQ && !pickup))) begin
			vd = V_REFUSED;
		end else begin
			if (pkt.func) begin
				base = TRK_RESET;
			end
			if (pkt.pkt_type == TY_RESET && !pkt.reply_seen) begin
				trk_nxt = TRK_RESET;
				vd      = V_KILL;
			end else begin
				role    = base.orig_srv ^ pkt.direction;
				ns      = ns_lookup(role, pkt.pkt_type, 3'(base.track));
				fin     = ns;
				trk_nxt = base;
				vd      = V_ACCEPT;
				case (ns)
					NX_RQ: begin
						// re-request after TIMEWAIT from the other side swaps roles
						if (base.track == ST_TW && role) begin
							trk_nxt.orig_srv = ~base.orig_srv;
						end
					end
					NX_RS: begin
						if (base.track == ST_RQ) begin
							trk_nxt.hs_seq = pkt.seq_number;
						end
					end
					NX_PO: begin
						if (base.track == ST_RS && pkt.pkt_type == TY_ACK &&
								pkt.ack_number == base.hs_seq) begin
							trk_nxt.assured = 1'b1;
						end
					end
					NX_IG: begin
						// simultaneous open: response answering our own request
						if (base.prior_dir == ~pkt.direction && base.prior_type == TY_REQUEST &&
								pkt.pkt_type == TY_RESPONSE) begin
							trk_nxt.orig_srv = ~pkt.direction;
							trk_nxt.hs_seq   = pkt.seq_number;
							fin              = NX_RS;
						end else begin
							vd = V_IGNORE;
						end
					end
					NX_IV: begin
						vd = V_INVALID;
					end
					default: ;
				endcase
				if (vd != V_INVALID) begin
					trk_nxt.prior_dir  = pkt.direction;
					trk_nxt.prior_type = pkt.pkt_type;
				end
				if (vd == V_ACCEPT) begin
					trk_nxt.track = state_t'(fin[2:0]);
					if (trk_nxt.track != ST_NO) begin
						tidx  = 3'(trk_nxt.track) - 3'd1;
						ticks = tmo[tidx];
					end
				end
			end
		end

		res.verdict    = vd;
		res.conn_state = trk_nxt.track;
		res.changed    = (trk_nxt.track != trk.track);
		res.assured    = trk_nxt.assured;
		res.ticks      = ticks;
	end

endmodule
